// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle port check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle port check failed");

`endif

// ----- src/tts_pkg.sv -----
// Types and constants shared by the tick timestamp converter modules.
package tts_pkg;

   localparam logic [31:0] FreqReset     = 32'd32771798;
   localparam logic [19:0] UsecPerSec    = 20'd1000000;
   localparam int          DivCountWidth = 7;
   localparam logic [DivCountWidth-1:0] SecIterations  = 7'd64;
   localparam logic [DivCountWidth-1:0] UsecIterations = 7'd20;

   typedef enum logic [3:0] {
      StIdle,
      StSelect,
      StElapsed,
      StScaleA,
      StScaleB,
      StDivSec,
      StWaitSec,
      StMulUsec,
      StDivUsec,
      StWaitUsec,
      StSum,
      StDeliver
   } state_type;

   typedef struct packed {
      logic                     start;
      logic [DivCountWidth-1:0] iterations;
   } div_cmd_type;

   typedef struct packed {
      logic [63:0] origin;
      logic [31:0] seconds;
      logic [19:0] microseconds;
   } ref_type;

   // Extends a captured 32-bit tick to 64 bits as a value in the past of now.
   function automatic logic [63:0] extend_past(input logic [31:0] tick,
                                               input logic [63:0] now);
      logic borrow;
      borrow = tick[31] & ~now[31];
      return {now[63:32] - {31'b0, borrow}, tick};
   endfunction

endpackage

// ----- src/tts_divider.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
module tts_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  tts_pkg::div_cmd_type cmd,
   input  logic [31:0]          divisor,
   input  logic [31:0]          init_rem,
   input  logic [63:0]          init_bits,
   output logic                 done,
   output logic [63:0]          quotient,
   output logic [31:0]          remainder
);

   logic [31:0]                     rem_ff, rem_in;
   logic [63:0]                     bits_ff, bits_in;
   logic [tts_pkg::DivCountWidth-1:0] count_ff, count_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [32:0]                     trial;
   logic [32:0]                     diff;
   logic                            fits;

   // The dividend leaves the shift register at the top while quotient bits enter at the bottom.
   assign trial = {rem_ff, bits_ff[63]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in   = rem_ff;
      bits_in  = bits_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (cmd.start) begin
         rem_in   = init_rem;
         bits_in  = init_bits;
         count_in = cmd.iterations;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[31:0] : trial[31:0];
         bits_in  = {bits_ff[62:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == {{(tts_pkg::DivCountWidth-1){1'b0}}, 1'b1}) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = bits_ff;
   assign remainder = rem_ff;

endmodule

// ----- src/tts_refs.sv -----
// Store for the newest and the older time reference, with reference selection.
module tts_refs (
   input  logic             clock,
   input  logic             reset,
   input  logic             set_en,
   input  tts_pkg::ref_type set_ref,
   input  logic [63:0]      set_time,
   input  logic [63:0]      event_tick,
   output tts_pkg::ref_type sel_ref
);

   tts_pkg::ref_type new_ref_ff, old_ref_ff;
   logic [63:0]      new_set_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         new_ref_ff      <= '0;
         old_ref_ff      <= '0;
         new_set_time_ff <= '0;
      end else if (set_en) begin
         old_ref_ff      <= new_ref_ff;
         new_ref_ff      <= set_ref;
         new_set_time_ff <= set_time;
      end
   end

   // The newest reference applies only to events strictly after it was set.
   assign sel_ref = (event_tick > new_set_time_ff) ? new_ref_ff : old_ref_ff;

endmodule

// ----- src/tick_timestamp_converter_core.sv -----
// Top level of the tick timestamp converter: sequencer and datapath.
//
// The block turns captured 32-bit timer ticks into unix seconds and microseconds.
// Requests arrive on the req_ channel as valid/ready transactions. A transaction
// with req_mode low installs a new time reference: the newest reference moves to
// the older slot and the request's origin tick, seconds, microseconds and the
// current tick count become the newest one. It produces no response and the
// block is ready again in the next cycle. A transaction with req_mode high
// converts req_tick_low and yields one response transaction on the rsp_ channel.
// A conversion runs from acceptance to a valid response through a
// 64-step bit-serial division of the scaled elapsed ticks by the frequency
// register, a 20-step division for the microseconds, and the sequencing states
// around them. One conversion is in flight at a time; req_ready is high only when
// the sequencer is idle, so no request is taken while a conversion runs.
// The response sits in an output register, so a new request is taken while a
// finished response waits; a stalled receiver holds the sequencer only when the
// next response is ready to be written. The csr_ channel writes the frequency
// register (ticks per second times 1000) and is always ready; the user must
// write it only while the block is idle, which the block does not enforce.
// Synchronous reset clears both references and restores the default frequency.
module tick_timestamp_converter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [31:0] req_tick_low,
   input  logic [63:0] req_now_ticks,
   input  logic [31:0] req_ref_seconds,
   input  logic [19:0] req_ref_microseconds,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_seconds,
   output logic [19:0] rsp_microseconds,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_milli_frequency
);

   tts_pkg::state_type   state_ff, state_in;
   tts_pkg::div_cmd_type div_cmd;
   tts_pkg::ref_type     set_ref;
   tts_pkg::ref_type     sel_ref;

   logic [31:0] freq_ff;
   logic [63:0] ext_ff;          // extended event tick, then elapsed ticks
   logic [63:0] scaled_ff;
   logic [63:0] origin_ff;
   logic [31:0] base_sec_ff;
   logic [19:0] base_usec_ff;
   logic        zero_div_ff;
   logic [31:0] sec_ff;
   logic [51:0] prod_ff;
   logic [19:0] usec_ff;
   logic [31:0] sec_sum_ff;
   logic [20:0] usec_sum_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_seconds_ff;
   logic [19:0] rsp_microseconds_ff;

   logic        req_accept;
   logic        refs_set;
   logic        out_free;
   logic        carry;
   logic [63:0] ext_tick;
   logic [31:0] div_init_rem;
   logic [63:0] div_init_bits;
   logic        div_done;
   logic [63:0] div_quotient;
   logic [31:0] div_remainder;
   logic [20:0] usec_wrapped;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ext_tick   = tts_pkg::extend_past(req_tick_low, req_now_ticks);

   assign set_ref.origin       = ext_tick;
   assign set_ref.seconds      = req_ref_seconds;
   assign set_ref.microseconds = req_ref_microseconds;

   tts_refs u_refs (
      .clock      (clock),
      .reset      (reset),
      .set_en     (refs_set),
      .set_ref    (set_ref),
      .set_time   (req_now_ticks),
      .event_tick (ext_ff),
      .sel_ref    (sel_ref)
   );

   // The seconds division starts from an empty remainder. For the microseconds the
   // quotient is known to be under 2^20, so the top of the product already lies
   // below the divisor and only twenty steps remain.
   assign div_init_rem  = (state_ff == tts_pkg::StDivUsec) ? prod_ff[51:20] : 32'b0;
   assign div_init_bits = (state_ff == tts_pkg::StDivUsec) ? {prod_ff[19:0], 44'b0}
                                                           : scaled_ff;

   tts_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .cmd       (div_cmd),
      .divisor   (freq_ff),
      .init_rem  (div_init_rem),
      .init_bits (div_init_bits),
      .done      (div_done),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tts_pkg::StIdle: begin
            if (req_valid && req_mode) state_in = tts_pkg::StSelect;
         end
         tts_pkg::StSelect:   state_in = tts_pkg::StElapsed;
         tts_pkg::StElapsed:  state_in = tts_pkg::StScaleA;
         tts_pkg::StScaleA:   state_in = tts_pkg::StScaleB;
         tts_pkg::StScaleB:   state_in = tts_pkg::StDivSec;
         tts_pkg::StDivSec:   state_in = tts_pkg::StWaitSec;
         tts_pkg::StWaitSec: begin
            if (div_done) state_in = tts_pkg::StMulUsec;
         end
         tts_pkg::StMulUsec:  state_in = tts_pkg::StDivUsec;
         tts_pkg::StDivUsec:  state_in = tts_pkg::StWaitUsec;
         tts_pkg::StWaitUsec: begin
            if (div_done) state_in = tts_pkg::StSum;
         end
         tts_pkg::StSum:      state_in = tts_pkg::StDeliver;
         tts_pkg::StDeliver: begin
            if (out_free) state_in = tts_pkg::StIdle;
         end
         default:             state_in = tts_pkg::StIdle;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready          = 1'b0;
      refs_set           = 1'b0;
      div_cmd.start      = 1'b0;
      div_cmd.iterations = tts_pkg::SecIterations;
      case (state_ff)
         tts_pkg::StIdle: begin
            req_ready = 1'b1;
            refs_set  = req_valid && !req_mode;
         end
         tts_pkg::StDivSec: begin
            div_cmd.start = 1'b1;
         end
         tts_pkg::StDivUsec: begin
            div_cmd.start      = 1'b1;
            div_cmd.iterations = tts_pkg::UsecIterations;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Scaling by 1000 is done as 1024 - 32 + 8 in the StScaleA and StScaleB states.
   assign carry        = (usec_sum_ff >= {1'b0, tts_pkg::UsecPerSec});
   assign usec_wrapped = usec_sum_ff - {1'b0, tts_pkg::UsecPerSec};

   always_ff @(posedge clock) begin
      case (state_ff)
         tts_pkg::StIdle: begin
            if (req_accept) ext_ff <= ext_tick;
         end
         tts_pkg::StSelect: begin
            origin_ff    <= sel_ref.origin;
            base_sec_ff  <= sel_ref.seconds;
            base_usec_ff <= sel_ref.microseconds;
            zero_div_ff  <= (freq_ff == 32'b0);
         end
         tts_pkg::StElapsed: begin
            ext_ff <= ext_ff - origin_ff;
         end
         tts_pkg::StScaleA: begin
            scaled_ff <= {ext_ff[53:0], 10'b0} - {ext_ff[58:0], 5'b0};
         end
         tts_pkg::StScaleB: begin
            scaled_ff <= scaled_ff + {ext_ff[60:0], 3'b0};
         end
         tts_pkg::StWaitSec: begin
            if (div_done) sec_ff <= zero_div_ff ? 32'b0 : div_quotient[31:0];
         end
         tts_pkg::StMulUsec: begin
            prod_ff <= 52'(div_remainder) * 52'(tts_pkg::UsecPerSec);
         end
         tts_pkg::StWaitUsec: begin
            if (div_done) usec_ff <= zero_div_ff ? 20'b0 : div_quotient[19:0];
         end
         tts_pkg::StSum: begin
            sec_sum_ff  <= sec_ff + base_sec_ff;
            usec_sum_ff <= {1'b0, usec_ff} + {1'b0, base_usec_ff};
         end
         tts_pkg::StDeliver: begin
            if (out_free) begin
               rsp_seconds_ff      <= sec_sum_ff + {31'b0, carry};
               rsp_microseconds_ff <= carry ? usec_wrapped[19:0] : usec_sum_ff[19:0];
            end
         end
         default: begin
            sec_ff <= sec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tts_pkg::StIdle;
         freq_ff      <= tts_pkg::FreqReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) freq_ff <= csr_milli_frequency;
         if ((state_ff == tts_pkg::StDeliver) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_seconds      = rsp_seconds_ff;
   assign rsp_microseconds = rsp_microseconds_ff;

endmodule

// ----- src/tts_checker.sv -----
// Port-level checker for the tick timestamp converter, bound to the top level.
`include "assert_macros.svh"

module tts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_seconds,
   input logic [19:0] rsp_microseconds
);

   // A stalled response stays offered.
   `ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // A stalled response keeps its payload.
   `ASSERT_NEXT(rsp_stable_a, clock, reset, rsp_valid && !rsp_ready,
                $stable(rsp_seconds) && $stable(rsp_microseconds))

   // A conversion occupies the block, so no request is taken just after one.
   `ASSERT_NEXT(busy_after_convert_a, clock, reset,
                req_valid && req_ready && req_mode, !req_ready)

   // Installing a reference never produces a response and leaves the block ready.
   `ASSERT_NEXT(set_silent_a, clock, reset,
                req_valid && req_ready && !req_mode && !rsp_valid,
                !rsp_valid && req_ready)

endmodule

bind tick_timestamp_converter_core tts_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_seconds      (rsp_seconds),
   .rsp_microseconds (rsp_microseconds)
);
